[rtl/core/tcnc_pkg.sv]
// Package for the tick count / nanosecond converter: constants and pipeline item type.
`timescale 1ns / 1ps
package tcnc_pkg;

    localparam int unsigned FreqW  = 34;
    localparam int unsigned ValW   = 64;
    localparam int unsigned Stages = 64;

    localparam logic [FreqW-1:0] NsPerSec  = 34'd1000000000;
    localparam logic [FreqW-1:0] FreqReset = 34'd1000000000;

    typedef struct packed {
        logic             valid;
        logic [FreqW-1:0] d;
        logic [FreqW-1:0] m;
        logic [FreqW-1:0] r;
        logic [ValW-1:0]  x;
        logic [ValW-1:0]  q;
    } t_div_item;

endpackage

[rtl/core/tcnc_div_cell.sv]
// One restoring division cell: produces one quotient bit per item.
`timescale 1ns / 1ps
module tcnc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  tcnc_pkg::t_div_item i_item,
    output tcnc_pkg::t_div_item o_item
);
    import tcnc_pkg::*;

    t_div_item      r_item;
    t_div_item      n_item;
    logic [FreqW:0] trial;
    logic [FreqW:0] diff;
    logic           qbit;

    always_comb begin
        trial  = {i_item.r, i_item.x[ValW-1]};
        diff   = trial - {1'b0, i_item.d};
        qbit   = (trial >= {1'b0, i_item.d});
        n_item = i_item;
        n_item.r = qbit ? diff[FreqW-1:0] : trial[FreqW-1:0];
        n_item.x = {i_item.x[ValW-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_item.valid <= n_item.valid;
        end
        if (i_adv) begin
            r_item.d <= n_item.d;
            r_item.m <= n_item.m;
            r_item.r <= n_item.r;
            r_item.x <= n_item.x;
            r_item.q <= n_item.q;
        end
    end

    assign o_item = r_item;

endmodule

[rtl/core/tcnc_div_chain.sv]
// Row of division cells giving a full 64-bit quotient and a 34-bit remainder.
`timescale 1ns / 1ps
module tcnc_div_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  tcnc_pkg::t_div_item i_item,
    output tcnc_pkg::t_div_item o_item
);
    import tcnc_pkg::*;

    t_div_item link [Stages+1];

    assign link[0] = i_item;

    for (genvar g = 0; g < Stages; g++) begin : g_cell
        tcnc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (i_adv),
            .i_item (link[g]),
            .o_item (link[g+1])
        );
    end

    assign o_item = link[Stages];

endmodule

[rtl/core/tick_count_ns_converter_unit.sv]
// Top level: tick count <-> nanosecond converter pipeline.
//
// Input channel: i_valid / o_stall with i_kind and i_operand_value. Kind 0
// turns a tick count into nanoseconds, kind 1 nanoseconds into ticks.
// Output channel: o_valid / i_stall with o_converted_value.
// The tick frequency is written through i_cfg_wr_en / i_cfg_wr_data while
// the block is idle; a frequency of zero acts as one hertz.
// Throughput: one item per cycle while the output is not stalled. The
// pipeline holds two rows of 64 division cells (one quotient bit per cell),
// one multiply stage, one partial product stage and the output register.
// Reset clears all valid bits and loads a frequency of 1 GHz.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises; otherwise bubbles move on and items keep flowing.
`timescale 1ns / 1ps
module tick_count_ns_converter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tcnc_pkg::FreqW-1:0] i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_kind,
    input  logic [tcnc_pkg::ValW-1:0]  i_operand_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tcnc_pkg::ValW-1:0]  o_converted_value
);
    import tcnc_pkg::*;

    logic [FreqW-1:0]   r_freq;
    logic [FreqW-1:0]   freq_eff;
    logic               adv;
    t_div_item          item_in;
    t_div_item          c1;
    t_div_item          r_mid;
    t_div_item          c2;
    logic [2*FreqW-1:0] prod;
    logic               r_p_valid;
    logic [ValW-1:0]    r_p_lo;
    logic [31:0]        r_p_hi;
    logic [ValW-1:0]    r_p_frac;
    logic [FreqW+31:0]  lo_full;
    logic [FreqW+31:0]  hi_full;
    logic               r_out_valid;
    logic [ValW-1:0]    r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FreqReset;
        end else if (i_cfg_wr_en) begin
            r_freq <= i_cfg_wr_data;
        end
    end

    assign freq_eff = (r_freq == '0) ? FreqW'(1) : r_freq;
    assign adv      = !(r_out_valid && i_stall);
    assign o_stall  = !adv;

    always_comb begin
        item_in.valid = i_valid;
        item_in.d     = i_kind ? NsPerSec : freq_eff;
        item_in.m     = i_kind ? freq_eff : NsPerSec;
        item_in.r     = '0;
        item_in.x     = i_operand_value;
        item_in.q     = '0;
    end

    tcnc_div_chain u_div_sec (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_item (item_in),
        .o_item (c1)
    );

    // leftover times multiplier, known to fit in 64 bits
    assign prod = c1.r * c1.m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
        end else if (adv) begin
            r_mid.valid <= c1.valid;
        end
        if (adv) begin
            r_mid.d <= c1.d;
            r_mid.m <= c1.m;
            r_mid.r <= '0;
            r_mid.x <= prod[ValW-1:0];
            r_mid.q <= c1.x;
        end
    end

    tcnc_div_chain u_div_frac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_item (r_mid),
        .o_item (c2)
    );

    // seconds times multiplier, split in two 32-bit halves
    assign lo_full = c2.q[31:0] * c2.m;
    assign hi_full = c2.q[63:32] * c2.m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= c2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_lo   <= lo_full[ValW-1:0];
            r_p_hi   <= hi_full[31:0];
            r_p_frac <= c2.x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= r_p_lo + {r_p_hi, 32'd0} + r_p_frac;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_converted_value = r_out;

endmodule

[sim/tick_count_ns_checker.sv]
// Checker: watches both channels, predicts each conversion and compares results.
`timescale 1ns / 1ps
module tick_count_ns_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tcnc_pkg::FreqW-1:0] i_cfg_wr_data,
    input  logic                       i_valid,
    input  logic                       i_stall_in,
    input  logic                       i_kind,
    input  logic [tcnc_pkg::ValW-1:0]  i_operand_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [tcnc_pkg::ValW-1:0]  i_converted_value,
    output int                         o_errors,
    output int                         o_pending
);
    import tcnc_pkg::*;

    logic [ValW-1:0] expected_ns_q[$];
    logic [FreqW-1:0] freq_hz;

    function automatic logic [ValW-1:0] convert(input logic kind, input logic [ValW-1:0] v,
                                                input logic [FreqW-1:0] fr);
        logic [ValW-1:0] f;
        logic [ValW-1:0] secs;
        logic [ValW-1:0] left;
        logic [ValW-1:0] frac;
        f = (fr == '0) ? 64'd1 : {30'd0, fr};
        if (!kind) begin
            secs = v / f;
            left = v - secs * f;
            frac = (left * 64'd1000000000) / f;
            return secs * 64'd1000000000 + frac;
        end else begin
            secs = v / 64'd1000000000;
            left = v - secs * 64'd1000000000;
            frac = (left * f) / 64'd1000000000;
            return secs * f + frac;
        end
    endfunction

    assign o_pending = expected_ns_q.size();

    always @(posedge i_clk) begin
        logic [ValW-1:0] exp_v;
        if (!i_rst_n) begin
            freq_hz <= FreqReset;
            expected_ns_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_wr_en)
                freq_hz <= i_cfg_wr_data;
            if (i_valid && !i_stall_in)
                expected_ns_q.push_back(convert(i_kind, i_operand_value, freq_hz));
            if (i_out_valid && !i_out_stall) begin
                if (expected_ns_q.size() == 0) begin
                    $display("%0t: unexpected item, actual %0d", $time, i_converted_value);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_v = expected_ns_q.pop_front();
                    if (exp_v !== i_converted_value) begin
                        $display("%0t: mismatch, expected %0d actual %0d",
                                 $time, exp_v, i_converted_value);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/tick_count_ns_converter_unit_tb.sv]
// Testbench top: drives conversions and frequency writes, reports the verdict.
`timescale 1ns / 1ps
module tick_count_ns_converter_unit_tb;
    import tcnc_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [FreqW-1:0] i_cfg_wr_data = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_kind = 1'b0;
    logic [ValW-1:0]  i_operand_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [ValW-1:0]  o_converted_value;
    int               errors;
    int               pending;
    int               cycles = 0;
    bit               calm = 1'b0;

    localparam int MaxCycles = 400000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tick_count_ns_converter_unit dut (.*);

    tick_count_ns_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data,
        .i_valid, .i_stall_in(o_stall), .i_kind, .i_operand_value,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_converted_value(o_converted_value),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MaxCycles) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end

    task automatic send(input logic kind, input logic [ValW-1:0] v);
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_operand_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_freq(input logic [FreqW-1:0] f);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (140) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= f;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ValW-1:0] rand_val();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom);
            2: return {$urandom, $urandom} >> $urandom_range(63);
            default: return {$urandom, $urandom} | 64'hF000_0000_0000_0000;
        endcase
    endfunction

    function automatic logic [FreqW-1:0] rand_freq();
        case ($urandom_range(3))
            0: return FreqW'($urandom_range(1000));
            1: return FreqW'({$urandom, $urandom});
            2: return FreqW'(64'd10000000000 - $urandom_range(1000));
            default: return FreqW'($urandom_range(2000000000, 1000));
        endcase
    endfunction

    initial begin
        logic [FreqW-1:0] freqs [6];
        freqs = '{34'd1000000000, 34'd1, 34'd0, 34'h3FFFFFFFF, 34'd10000000000, 34'd3};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (freqs[k]) begin
            if (k != 0) set_freq(freqs[k]);
            for (int kd = 0; kd < 2; kd++) begin
                send(kd[0], 64'd0);
                send(kd[0], '1);
                send(kd[0], 64'd999999999);
                send(kd[0], 64'd1000000000);
            end
        end
        for (int ph = 0; ph < 10; ph++) begin
            set_freq(rand_freq());
            calm = (ph == 4);
            for (int n = 0; n < 100; n++) send(1'($urandom_range(1)), rand_val());
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (140) @(negedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[tick_count_ns_converter_unit.f]
rtl/core/tcnc_pkg.sv
rtl/core/tcnc_div_cell.sv
rtl/core/tcnc_div_chain.sv
rtl/core/tick_count_ns_converter_unit.sv
sim/tick_count_ns_checker.sv
sim/tick_count_ns_converter_unit_tb.sv
